@@ sv/fbr_pkg.sv @@
// ----------------------------------------------------------------------------
// fbr_pkg
// Shared types and codes for the BLE control-point fragment reassembler.
// ----------------------------------------------------------------------------
package fbr_pkg;

   // Status given on the last byte of each write
   typedef enum logic [2:0] {
      ST_NONE     = 3'd0,
      ST_MORE     = 3'd1,
      ST_DONE     = 3'd2,
      ST_SHORT    = 3'd3,
      ST_LONG     = 3'd4,
      ST_SEQ      = 3'd5,
      ST_OVERSIZE = 3'd6
   } status_type;

   // Field widths fixed by the frame format
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 12;
   localparam int LENGTH_W = 13;
   localparam int DECL_W   = 16;

   // Bit 7 of a write's first byte marks an initial frame
   localparam int INIT_BIT = 7;

   // One result item
   typedef struct packed {
      logic                  payload_valid;
      logic [BYTE_W-1:0]     payload_byte;
      logic [OFFSET_W-1:0]   payload_offset;
      logic                  write_done;
      status_type            frame_status;
      logic [BYTE_W-1:0]     command_code;
      logic [LENGTH_W-1:0]   message_length;
   } result_type;

endpackage

@@ sv/fbr_frag_core.sv @@
// ----------------------------------------------------------------------------
// fbr_frag_core
// Reassembly state and per-byte decode: frame header parsing, sequence
// check, payload offset counting and end-of-write status.
// ----------------------------------------------------------------------------
module fbr_frag_core #(
   parameter int MAX_MESSAGE = 4096,
   parameter int MAX_WRITE   = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [fbr_pkg::BYTE_W-1:0]  data_byte,
   input  logic                        write_end,
   output fbr_pkg::result_type         result
);

   localparam int BPW = $clog2(MAX_WRITE + 1);
   localparam int BRW = $clog2(MAX_MESSAGE + 1);

   // State registers
   logic [BPW-1:0]                 bp_ff, bp_in;
   logic                           init_ff, init_in;
   logic                           wf_ff, wf_in;
   fbr_pkg::status_type            fc_ff, fc_in;
   logic [fbr_pkg::BYTE_W-1:0]     cmd_ff, cmd_in;
   logic [fbr_pkg::DECL_W-1:0]     tl_ff, tl_in;
   logic [BRW-1:0]                 br_ff, br_in;
   logic [fbr_pkg::BYTE_W-1:0]     seq_ff, seq_in;
   logic                           await_ff, await_in;

   logic                           pv;
   logic [BRW-1:0]                 poff;
   fbr_pkg::status_type            st;

   // Per-byte decode
   always_comb begin
      bp_in    = bp_ff;
      init_in  = init_ff;
      wf_in    = wf_ff;
      fc_in    = fc_ff;
      cmd_in   = cmd_ff;
      tl_in    = tl_ff;
      br_in    = br_ff;
      seq_in   = seq_ff;
      await_in = await_ff;
      pv       = 1'b0;
      poff     = '0;
      st       = fbr_pkg::ST_NONE;

      if (bp_ff >= BPW'(MAX_WRITE)) begin
         // bytes past the write limit: oversize wins over other errors
         fc_in = fbr_pkg::ST_OVERSIZE;
         wf_in = 1'b1;
      end else if (bp_ff == '0) begin
         init_in = data_byte[fbr_pkg::INIT_BIT];
         if (data_byte[fbr_pkg::INIT_BIT]) begin
            cmd_in   = data_byte;
            tl_in    = '0;
            br_in    = '0;
            await_in = 1'b0;
            seq_in   = '0;
         end else if (!await_ff || data_byte != seq_ff) begin
            if (!wf_ff) fc_in = fbr_pkg::ST_SEQ;
            wf_in = 1'b1;
         end
      end else if (init_ff && bp_ff == BPW'(1)) begin
         tl_in = {data_byte, 8'h00};
      end else if (init_ff && bp_ff == BPW'(2)) begin
         tl_in = {tl_ff[fbr_pkg::DECL_W-1:fbr_pkg::BYTE_W], data_byte};
         if ({tl_ff[fbr_pkg::DECL_W-1:fbr_pkg::BYTE_W], data_byte}
               > fbr_pkg::DECL_W'(MAX_MESSAGE)) begin
            if (!wf_ff) fc_in = fbr_pkg::ST_LONG;
            wf_in = 1'b1;
         end
      end else if (!wf_ff) begin
         if (fbr_pkg::DECL_W'(br_ff) >= tl_ff) begin
            fc_in = fbr_pkg::ST_LONG;
            wf_in = 1'b1;
         end else begin
            pv    = 1'b1;
            poff  = br_ff;
            br_in = br_ff + BRW'(1);
         end
      end

      // position within the write saturates at the limit
      if (bp_ff < BPW'(MAX_WRITE)) bp_in = bp_ff + BPW'(1);

      // end of write: status and reassembly bookkeeping
      if (write_end) begin
         if (wf_in) begin
            st = fc_in;
         end else if (init_in && bp_ff < BPW'(2)) begin
            st = fbr_pkg::ST_SHORT;
         end else if (fbr_pkg::DECL_W'(br_in) == tl_in) begin
            st = fbr_pkg::ST_DONE;
         end else begin
            st = fbr_pkg::ST_MORE;
         end
         if (st == fbr_pkg::ST_MORE) begin
            seq_in   = init_in ? '0 : seq_in + 8'd1;
            await_in = 1'b1;
         end else begin
            await_in = 1'b0;
            br_in    = '0;
            seq_in   = '0;
         end
         bp_in   = '0;
         wf_in   = 1'b0;
         fc_in   = fbr_pkg::ST_NONE;
         init_in = 1'b0;
      end
   end

   // Result item
   always_comb begin
      result.payload_valid  = pv;
      result.payload_byte   = pv ? data_byte : '0;
      result.payload_offset = fbr_pkg::OFFSET_W'(poff);
      result.write_done     = write_end;
      result.frame_status   = st;
      result.command_code   = cmd_in;
      result.message_length = fbr_pkg::LENGTH_W'(tl_in);
   end

   // State update, one byte per step
   always_ff @(posedge clock) begin
      if (reset) begin
         bp_ff    <= '0;
         init_ff  <= 1'b0;
         wf_ff    <= 1'b0;
         fc_ff    <= fbr_pkg::ST_NONE;
         cmd_ff   <= '0;
         tl_ff    <= '0;
         br_ff    <= '0;
         seq_ff   <= '0;
         await_ff <= 1'b0;
      end else if (step) begin
         bp_ff    <= bp_in;
         init_ff  <= init_in;
         wf_ff    <= wf_in;
         fc_ff    <= fc_in;
         cmd_ff   <= cmd_in;
         tl_ff    <= tl_in;
         br_ff    <= br_in;
         seq_ff   <= seq_in;
         await_ff <= await_in;
      end
   end

   // Checks
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      bp_ff <= BPW'(MAX_WRITE))
      else $error("write position beyond limit");

   // between writes, an awaited continuation means the message is not full
   a_await_short: assert property (@(posedge clock) disable iff (reset)
      await_ff && bp_ff == '0 |-> fbr_pkg::DECL_W'(br_ff) < tl_ff)
      else $error("continuation awaited with message already full");

   a_seq_idle: assert property (@(posedge clock) disable iff (reset)
      !await_ff |-> seq_ff == '0)
      else $error("sequence not cleared while idle");

   a_fail_code: assert property (@(posedge clock) disable iff (reset)
      wf_ff |-> fc_ff != fbr_pkg::ST_NONE)
      else $error("failed write without error code");

   a_count: assert property (@(posedge clock) disable iff (reset)
      step && pv && !write_end |=> br_ff == $past(br_ff) + BRW'(1))
      else $error("payload counter did not advance");

endmodule

@@ sv/fido_ble_fragment_reassembler.sv @@
// ----------------------------------------------------------------------------
// fido_ble_fragment_reassembler
// FIDO BLE control-point write reassembler: one byte per item in, one
// result item out with payload byte, offset and end-of-write status.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is held in the input register, then decoded
//   into the result register, which drives rsp_tvalid.
// Throughput: one item per cycle while rsp_tready stays high; a stalled
//   result holds the input register, so at most one more item is taken.
// Reset: synchronous; clears both valid flags and all reassembly state.
// ----------------------------------------------------------------------------
module fido_ble_fragment_reassembler #(
   parameter int MAX_MESSAGE = 4096,
   parameter int MAX_WRITE   = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // write_end
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] payload_byte, [19:8] payload_offset,
                                    // [27:20] command_code, [40:28] message_length,
                                    // [47:41] zero
   output logic [3:0]  rsp_tuser,   // [0] payload_valid, [3:1] frame_status
   output logic        rsp_tlast    // write_done
);

   // Input register
   logic                        s1_valid_ff;
   logic [fbr_pkg::BYTE_W-1:0]  s1_data_ff;
   logic                        s1_last_ff;

   // Result register
   logic                        out_valid_ff;
   fbr_pkg::result_type         out_ff;

   fbr_pkg::result_type         result;
   logic                        advance;

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_data_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
   end

   fbr_frag_core #(
      .MAX_MESSAGE (MAX_MESSAGE),
      .MAX_WRITE   (MAX_WRITE)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (s1_data_ff),
      .write_end (s1_last_ff),
      .result    (result)
   );

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance) out_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0, out_ff.message_length, out_ff.command_code,
                        out_ff.payload_offset, out_ff.payload_byte};
   assign rsp_tuser  = {out_ff.frame_status, out_ff.payload_valid};
   assign rsp_tlast  = out_ff.write_done;

endmodule
